// ----- hdl/mma_pkg.sv -----
package mma_pkg;

    localparam int FRACTION_BITS_DEF = 16;

    // Intermediate values are signed and limited to +-(2^40 - 1).
    localparam int MAG_W = 40;
    localparam int VAL_W = MAG_W + 1;
    localparam int ACC_W = 48;

    localparam logic signed [VAL_W-1:0] VAL_LIM = {1'b0, {MAG_W{1'b1}}};

    localparam logic [1:0] CFG_TAU   = 2'd0;
    localparam logic [1:0] CFG_OBJ   = 2'd1;
    localparam logic [1:0] CFG_OUTER = 2'd2;

    typedef enum logic [1:0] {
        CMD_VALUE,
        CMD_GRAD,
        CMD_HESS,
        CMD_NOP
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MUL,
        ST_DIV,
        ST_ACC,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_MUL,
        OP_DIV
    } t_op;

    typedef enum logic [3:0] {
        SRC_A,
        SRC_DOUT,
        SRC_D,
        SRC_DX,
        SRC_TAU,
        SRC_TAU2,
        SRC_ONE,
        SRC_R0,
        SRC_R1,
        SRC_R2,
        SRC_R3
    } t_src;

    typedef enum logic [1:0] {
        NEG_NONE,
        NEG_ALWAYS,
        NEG_LOWER
    } t_neg;

    typedef enum logic [1:0] {
        DST_R0,
        DST_R1,
        DST_R2,
        DST_R3
    } t_dst;

    typedef struct packed {
        t_op  op;
        t_src src_a;
        t_src src_b;
        t_neg neg_b;
        t_dst dst;
        logic done;
    } t_uop;

    function automatic t_uop mk_uop(t_op op, t_src sa, t_src sb, t_neg ng, t_dst dst,
                                    logic done);
        t_uop u;
        u.op    = op;
        u.src_a = sa;
        u.src_b = sb;
        u.neg_b = ng;
        u.dst   = dst;
        u.done  = done;
        return u;
    endfunction

    // Micro-program for each command. The element term always ends up in R1.
    function automatic t_uop prog_rom(t_cmd cmd, logic [3:0] step);
        t_uop u;
        u = mk_uop(OP_ADD, SRC_R1, SRC_R1, NEG_ALWAYS, DST_R1, 1'b1);
        if (cmd == CMD_VALUE) begin
            case (step)
                4'd0:    u = mk_uop(OP_MUL, SRC_A,    SRC_DOUT, NEG_NONE,   DST_R0, 1'b0);
                4'd1:    u = mk_uop(OP_MUL, SRC_R0,   SRC_DOUT, NEG_NONE,   DST_R1, 1'b0);
                4'd2:    u = mk_uop(OP_DIV, SRC_R1,   SRC_D,    NEG_NONE,   DST_R1, 1'b0);
                4'd3:    u = mk_uop(OP_MUL, SRC_DX,   SRC_DX,   NEG_NONE,   DST_R2, 1'b0);
                4'd4:    u = mk_uop(OP_MUL, SRC_TAU,  SRC_R2,   NEG_NONE,   DST_R2, 1'b0);
                4'd5:    u = mk_uop(OP_DIV, SRC_R2,   SRC_D,    NEG_NONE,   DST_R2, 1'b0);
                4'd6:    u = mk_uop(OP_ADD, SRC_R1,   SRC_R0,   NEG_ALWAYS, DST_R1, 1'b0);
                4'd7:    u = mk_uop(OP_ADD, SRC_R1,   SRC_R2,   NEG_NONE,   DST_R1, 1'b1);
                default: u = mk_uop(OP_ADD, SRC_R1,   SRC_R2,   NEG_NONE,   DST_R1, 1'b1);
            endcase
        end else begin
            case (step)
                4'd0:  u = mk_uop(OP_DIV, SRC_DOUT, SRC_D,  NEG_NONE, DST_R0, 1'b0);
                4'd1:  u = mk_uop(OP_MUL, SRC_A,    SRC_R0, NEG_NONE, DST_R1, 1'b0);
                4'd2:  u = mk_uop(OP_MUL, SRC_R1,   SRC_R0, NEG_NONE, DST_R1, 1'b0);
                4'd3:  u = mk_uop(OP_DIV, SRC_DX,   SRC_D,  NEG_NONE, DST_R0, 1'b0);
                4'd4:  u = mk_uop(OP_MUL, SRC_R0,   SRC_R0, NEG_NONE, DST_R2, 1'b0);
                4'd5:  u = mk_uop(OP_ADD, SRC_R0,   SRC_R0, NEG_NONE, DST_R3, 1'b0);
                default: begin
                    if (cmd == CMD_GRAD) begin
                        case (step)
                            4'd6: u = mk_uop(OP_ADD, SRC_R3, SRC_R2, NEG_LOWER, DST_R0, 1'b0);
                            4'd7: u = mk_uop(OP_MUL, SRC_TAU, SRC_R0, NEG_NONE, DST_R0, 1'b0);
                            default:
                                u = mk_uop(OP_ADD, SRC_R0, SRC_R1, NEG_LOWER, DST_R1, 1'b1);
                        endcase
                    end else begin
                        case (step)
                            4'd6:  u = mk_uop(OP_DIV, SRC_R1, SRC_D, NEG_NONE, DST_R1, 1'b0);
                            4'd7:  u = mk_uop(OP_ADD, SRC_ONE, SRC_R3, NEG_LOWER, DST_R0, 1'b0);
                            4'd8:  u = mk_uop(OP_ADD, SRC_R0, SRC_R2, NEG_NONE, DST_R0, 1'b0);
                            4'd9:  u = mk_uop(OP_MUL, SRC_TAU2, SRC_R0, NEG_NONE, DST_R0, 1'b0);
                            4'd10: u = mk_uop(OP_DIV, SRC_R0, SRC_D, NEG_NONE, DST_R0, 1'b0);
                            4'd11: u = mk_uop(OP_ADD, SRC_R1, SRC_R1, NEG_NONE, DST_R1, 1'b0);
                            default:
                                u = mk_uop(OP_ADD, SRC_R1, SRC_R0, NEG_NONE, DST_R1, 1'b1);
                        endcase
                    end
                end
            endcase
        end
        return u;
    endfunction

    function automatic logic [MAG_W-1:0] mag_of(logic signed [VAL_W-1:0] v);
        return v[VAL_W-1] ? MAG_W'(-v) : MAG_W'(v);
    endfunction

    function automatic logic signed [VAL_W-1:0] clamp_val(logic signed [VAL_W:0] v);
        logic signed [VAL_W:0] lim;
        lim = (VAL_W+1)'(VAL_LIM);
        if (v > lim) return VAL_LIM;
        if (v < -lim) return -VAL_LIM;
        return VAL_W'(v);
    endfunction

    function automatic logic ovf_val(logic signed [VAL_W:0] v);
        logic signed [VAL_W:0] lim;
        lim = (VAL_W+1)'(VAL_LIM);
        return (v > lim) || (v < -lim);
    endfunction

endpackage

// ----- hdl/mma_approximation_evaluator_core.sv -----
// Moving-asymptotes approximation evaluator.
//
// Input channel: i_valid / o_stall carry one design element per transfer with
// its command, gradient, points, asymptotes and last-element mark. The block
// takes one element at a time: o_stall stays high from the transfer until the
// element's work is done and its result, if any, sits in the output register.
// Output channel: o_valid / i_stall carry one result per transfer. Value runs
// give a result only on the last element; gradient and Hessian commands give
// one per element; the spare command code gives none.
// All arithmetic runs through one shared 42-bit adder. A multiply has an issue
// step, then takes one multiplier bit a cycle; a divide has an issue step, then
// makes one quotient bit a cycle; an add writes back in its issue step. After the
// arithmetic, a value element passes through the accumulate step, and a result
// passes through the output step.
// A result waiting under i_stall holds the output register; the next element
// is still taken and its work runs, then it waits until the register is free.
// Reset (synchronous, active low) clears the value sum, the error flag and the
// output valid bit, and sets the configuration registers to their reset values.
module mma_approximation_evaluator_core #(
    parameter int FRACTION_BITS = mma_pkg::FRACTION_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_command,
    input  logic signed [31:0] i_outer_gradient,
    input  logic signed [31:0] i_outer_point,
    input  logic signed [31:0] i_inner_point,
    input  logic signed [31:0] i_lower_asymptote,
    input  logic signed [31:0] i_upper_asymptote,
    input  logic               i_last_element,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_value,
    output logic               o_is_last,
    output logic               o_range_error,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    import mma_pkg::*;

    localparam int QW = MAG_W + FRACTION_BITS;
    localparam int CW = $clog2(QW);
    localparam int PW = 2 * MAG_W;
    localparam logic signed [VAL_W-1:0] ONE_V = VAL_W'(64'd1 << FRACTION_BITS);
    localparam logic signed [ACC_W:0] ACC_MAX = (ACC_W+1)'({1'b0, {(ACC_W-1){1'b1}}});
    localparam logic signed [ACC_W:0] ACC_MIN = -ACC_MAX - (ACC_W+1)'(1);
    localparam logic signed [ACC_W:0] S32_MAX = (ACC_W+1)'(33'sh0_7FFF_FFFF);
    localparam logic signed [ACC_W:0] S32_MIN = -S32_MAX - (ACC_W+1)'(1);

    // Configuration.
    logic [30:0]        r_tau;
    logic               r_obj;
    logic signed [31:0] r_outer;

    // Sequencer and element registers.
    t_state r_state, n_state;
    logic [3:0] r_step, n_step;
    t_cmd r_cmd, n_cmd;
    logic r_last, n_last;
    logic r_lower, n_lower;
    logic r_err, n_err;
    logic signed [VAL_W-1:0] r_a, n_a, r_dout, n_dout, r_d, n_d, r_dx, n_dx;
    logic [30:0] r_tau_e, n_tau_e;
    logic signed [VAL_W-1:0] r_r0, n_r0, r_r1, n_r1, r_r2, n_r2, r_r3, n_r3;

    // Shared multiply / divide unit.
    logic [MAG_W-1:0] r_hi, n_hi, r_ub, n_ub;
    logic [QW-1:0]    r_q, n_q;
    logic             r_neg, n_neg;
    logic [CW-1:0]    r_cnt, n_cnt;

    // Value run.
    logic signed [ACC_W-1:0] r_acc, n_acc;
    logic r_sticky, n_sticky;

    // Output register.
    logic               r_o_valid, n_o_valid;
    logic signed [31:0] r_o_value, n_o_value;
    logic               r_o_last, n_o_last, r_o_err, n_o_err;

    t_uop w_uop;
    t_cmd w_in_cmd;
    logic w_in_range, w_in_upper, w_in_acc;
    logic signed [32:0] w_up_xo, w_up_xi, w_xo_lo, w_xi_lo, w_dx_in, w_a_in;
    logic signed [VAL_W-1:0] w_va, w_vb, w_vb_n;
    logic w_neg_b, w_div_zero, w_mul_end, w_div_end, w_out_free;
    logic signed [VAL_W:0] w_alu_x, w_alu_y, w_alu_res;
    logic w_alu_sub;
    logic [PW-1:0] w_prod;
    logic [MAG_W:0] w_rem_sh;
    logic w_ge;
    logic [QW-1:0] w_q_new;
    logic [MAG_W-1:0] w_res_mag;
    logic w_res_ovf;
    logic signed [VAL_W-1:0] w_res_val;
    logic w_wr_en;
    logic signed [VAL_W-1:0] w_wr_val;
    logic w_wr_err;
    t_state w_fin_state;
    logic signed [ACC_W:0] w_acc_sum, w_total, w_term;

    assign w_uop    = prog_rom(r_cmd, r_step);
    assign w_in_cmd = t_cmd'(i_command);
    assign w_in_acc = i_valid && !o_stall;

    assign w_in_range = (i_lower_asymptote < i_outer_point) &&
                        (i_outer_point < i_upper_asymptote) &&
                        (i_lower_asymptote < i_inner_point) &&
                        (i_inner_point < i_upper_asymptote);
    assign w_in_upper = !i_outer_gradient[31];
    assign w_up_xo = 33'(i_upper_asymptote) - 33'(i_outer_point);
    assign w_up_xi = 33'(i_upper_asymptote) - 33'(i_inner_point);
    assign w_xo_lo = 33'(i_outer_point) - 33'(i_lower_asymptote);
    assign w_xi_lo = 33'(i_inner_point) - 33'(i_lower_asymptote);
    assign w_dx_in = 33'(i_inner_point) - 33'(i_outer_point);
    assign w_a_in  = w_in_upper ? 33'(i_outer_gradient) : 33'sd0 - 33'(i_outer_gradient);

    always_comb begin
        case (w_uop.src_a)
            SRC_A:    w_va = r_a;
            SRC_DOUT: w_va = r_dout;
            SRC_D:    w_va = r_d;
            SRC_DX:   w_va = r_dx;
            SRC_TAU:  w_va = VAL_W'({1'b0, r_tau_e});
            SRC_TAU2: w_va = VAL_W'({1'b0, r_tau_e, 1'b0});
            SRC_ONE:  w_va = ONE_V;
            SRC_R0:   w_va = r_r0;
            SRC_R1:   w_va = r_r1;
            SRC_R2:   w_va = r_r2;
            SRC_R3:   w_va = r_r3;
            default:  w_va = '0;
        endcase
        case (w_uop.src_b)
            SRC_A:    w_vb = r_a;
            SRC_DOUT: w_vb = r_dout;
            SRC_D:    w_vb = r_d;
            SRC_DX:   w_vb = r_dx;
            SRC_TAU:  w_vb = VAL_W'({1'b0, r_tau_e});
            SRC_TAU2: w_vb = VAL_W'({1'b0, r_tau_e, 1'b0});
            SRC_ONE:  w_vb = ONE_V;
            SRC_R0:   w_vb = r_r0;
            SRC_R1:   w_vb = r_r1;
            SRC_R2:   w_vb = r_r2;
            SRC_R3:   w_vb = r_r3;
            default:  w_vb = '0;
        endcase
    end

    assign w_neg_b = (w_uop.neg_b == NEG_ALWAYS) || ((w_uop.neg_b == NEG_LOWER) && r_lower);
    assign w_vb_n  = w_neg_b ? -w_vb : w_vb;
    assign w_div_zero = (mag_of(w_vb) == '0);

    // Shared adder: operand add, multiplier partial sum, divider trial subtract.
    assign w_rem_sh = {r_hi, r_q[QW-1]};
    always_comb begin
        case (r_state)
            ST_MUL: begin
                w_alu_x   = {2'b00, r_hi};
                w_alu_y   = r_q[0] ? {2'b00, r_ub} : '0;
                w_alu_sub = 1'b0;
            end
            ST_DIV: begin
                w_alu_x   = {1'b0, w_rem_sh};
                w_alu_y   = {2'b00, r_ub};
                w_alu_sub = 1'b1;
            end
            default: begin
                w_alu_x   = (VAL_W+1)'(w_va);
                w_alu_y   = (VAL_W+1)'(w_vb_n);
                w_alu_sub = 1'b0;
            end
        endcase
    end
    assign w_alu_res = w_alu_x + (w_alu_sub ? ~w_alu_y : w_alu_y) + (VAL_W+1)'(w_alu_sub);

    assign w_prod    = {w_alu_res[MAG_W:0], r_q[MAG_W-1:1]};
    assign w_ge      = !w_alu_res[VAL_W];
    assign w_q_new   = {r_q[QW-2:0], w_ge};
    assign w_mul_end = (r_cnt == CW'(MAG_W - 1));
    assign w_div_end = (r_cnt == CW'(QW - 1));

    always_comb begin
        if (r_state == ST_MUL) begin
            w_res_mag = w_prod[QW-1:FRACTION_BITS];
            w_res_ovf = |w_prod[PW-1:QW];
        end else begin
            w_res_mag = w_q_new[MAG_W-1:0];
            w_res_ovf = |w_q_new[QW-1:MAG_W];
        end
        w_res_val = w_res_ovf ? VAL_LIM : VAL_W'({1'b0, w_res_mag});
        if (r_neg) begin
            w_res_val = -w_res_val;
        end
    end

    // Register write-back from the shared unit.
    always_comb begin
        w_wr_en  = 1'b0;
        w_wr_val = '0;
        w_wr_err = 1'b0;
        case (r_state)
            ST_EXEC: begin
                if (w_uop.op == OP_ADD) begin
                    w_wr_en  = 1'b1;
                    w_wr_val = clamp_val(w_alu_res);
                    w_wr_err = ovf_val(w_alu_res);
                end else if (w_uop.op == OP_DIV && w_div_zero) begin
                    w_wr_en  = 1'b1;
                    w_wr_val = w_va[VAL_W-1] ? -VAL_LIM : VAL_LIM;
                    w_wr_err = 1'b1;
                end
            end
            ST_MUL: begin
                w_wr_en  = w_mul_end;
                w_wr_val = w_res_val;
                w_wr_err = w_res_ovf;
            end
            ST_DIV: begin
                w_wr_en  = w_div_end;
                w_wr_val = w_res_val;
                w_wr_err = w_res_ovf;
            end
            default: ;
        endcase
    end

    assign w_fin_state = (r_cmd == CMD_VALUE) ? ST_ACC : ST_OUT;
    assign w_out_free  = !r_o_valid || !i_stall;
    assign w_acc_sum   = (ACC_W+1)'(r_acc) + (ACC_W+1)'(r_r1);
    assign w_total     = (ACC_W+1)'(r_acc) + (ACC_W+1)'(r_outer);
    assign w_term      = (ACC_W+1)'(r_r1);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc && w_in_cmd != CMD_NOP) begin
                    if (w_in_range) begin
                        n_state = ST_EXEC;
                    end else if (w_in_cmd == CMD_VALUE) begin
                        n_state = ST_ACC;
                    end else begin
                        n_state = ST_OUT;
                    end
                end
            end
            ST_EXEC: begin
                if (w_wr_en) begin
                    n_state = w_uop.done ? w_fin_state : ST_EXEC;
                end else if (w_uop.op == OP_MUL) begin
                    n_state = ST_MUL;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_MUL, ST_DIV: begin
                if (w_wr_en) begin
                    n_state = w_uop.done ? w_fin_state : ST_EXEC;
                end
            end
            ST_ACC: n_state = r_last ? ST_OUT : ST_IDLE;
            ST_OUT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        n_step    = r_step;
        n_cmd     = r_cmd;
        n_last    = r_last;
        n_lower   = r_lower;
        n_err     = r_err;
        n_a       = r_a;
        n_dout    = r_dout;
        n_d       = r_d;
        n_dx      = r_dx;
        n_tau_e   = r_tau_e;
        n_r0      = r_r0;
        n_r1      = r_r1;
        n_r2      = r_r2;
        n_r3      = r_r3;
        n_hi      = r_hi;
        n_ub      = r_ub;
        n_q       = r_q;
        n_neg     = r_neg;
        n_cnt     = r_cnt;
        n_acc     = r_acc;
        n_sticky  = r_sticky;
        n_o_valid = r_o_valid;
        n_o_value = r_o_value;
        n_o_last  = r_o_last;
        n_o_err   = r_o_err;

        if (r_o_valid && !i_stall) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                n_step  = '0;
                n_cmd   = w_in_cmd;
                n_last  = i_last_element;
                n_lower = !w_in_upper;
                n_err   = !w_in_range;
                n_a     = VAL_W'(w_a_in);
                n_dout  = w_in_upper ? VAL_W'(w_up_xo) : VAL_W'(w_xo_lo);
                n_d     = w_in_upper ? VAL_W'(w_up_xi) : VAL_W'(w_xi_lo);
                n_dx    = VAL_W'(w_dx_in);
                n_tau_e = r_obj ? r_tau : '0;
                // An element out of range contributes a zero term.
                n_r1    = '0;
            end
            ST_EXEC: begin
                n_neg = (w_va[VAL_W-1] != w_vb[VAL_W-1]);
                n_ub  = mag_of(w_vb);
                n_hi  = '0;
                n_cnt = '0;
                if (w_uop.op == OP_MUL) begin
                    n_q = QW'(mag_of(w_va));
                end else begin
                    n_q = {mag_of(w_va), {FRACTION_BITS{1'b0}}};
                end
            end
            ST_MUL: begin
                n_hi = w_alu_res[MAG_W:1];
                n_q  = {r_q[QW-1:MAG_W], w_alu_res[0], r_q[MAG_W-1:1]};
                n_cnt = r_cnt + CW'(1);
            end
            ST_DIV: begin
                n_hi  = w_ge ? w_alu_res[MAG_W-1:0] : w_rem_sh[MAG_W-1:0];
                n_q   = w_q_new;
                n_cnt = r_cnt + CW'(1);
            end
            ST_ACC: begin
                n_sticky = r_sticky || r_err;
                if (w_acc_sum > ACC_MAX) begin
                    n_acc    = ACC_MAX[ACC_W-1:0];
                    n_sticky = 1'b1;
                end else if (w_acc_sum < ACC_MIN) begin
                    n_acc    = ACC_MIN[ACC_W-1:0];
                    n_sticky = 1'b1;
                end else begin
                    n_acc = w_acc_sum[ACC_W-1:0];
                end
            end
            ST_OUT: begin
                if (w_out_free) begin
                    n_o_valid = 1'b1;
                    n_o_last  = r_last;
                    if (r_cmd == CMD_VALUE) begin
                        n_o_err = r_sticky || (w_total > S32_MAX) || (w_total < S32_MIN);
                        if (w_total > S32_MAX) begin
                            n_o_value = 32'sh7FFF_FFFF;
                        end else if (w_total < S32_MIN) begin
                            n_o_value = 32'sh8000_0000;
                        end else begin
                            n_o_value = w_total[31:0];
                        end
                        n_acc    = '0;
                        n_sticky = 1'b0;
                    end else begin
                        n_o_err = r_err || (w_term > S32_MAX) || (w_term < S32_MIN);
                        if (w_term > S32_MAX) begin
                            n_o_value = 32'sh7FFF_FFFF;
                        end else if (w_term < S32_MIN) begin
                            n_o_value = 32'sh8000_0000;
                        end else begin
                            n_o_value = w_term[31:0];
                        end
                    end
                end
            end
            default: ;
        endcase

        if (w_wr_en) begin
            n_err  = r_err || w_wr_err;
            n_step = r_step + 4'd1;
            case (w_uop.dst)
                DST_R0:  n_r0 = w_wr_val;
                DST_R1:  n_r1 = w_wr_val;
                DST_R2:  n_r2 = w_wr_val;
                DST_R3:  n_r3 = w_wr_val;
                default: n_r1 = w_wr_val;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tau   <= '0;
            r_obj   <= 1'b1;
            r_outer <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TAU:   r_tau   <= i_cfg_data[30:0];
                CFG_OBJ:   r_obj   <= i_cfg_data[0];
                CFG_OUTER: r_outer <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_acc     <= '0;
            r_sticky  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_acc     <= n_acc;
            r_sticky  <= n_sticky;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step    <= n_step;
        r_cmd     <= n_cmd;
        r_last    <= n_last;
        r_lower   <= n_lower;
        r_err     <= n_err;
        r_a       <= n_a;
        r_dout    <= n_dout;
        r_d       <= n_d;
        r_dx      <= n_dx;
        r_tau_e   <= n_tau_e;
        r_r0      <= n_r0;
        r_r1      <= n_r1;
        r_r2      <= n_r2;
        r_r3      <= n_r3;
        r_hi      <= n_hi;
        r_ub      <= n_ub;
        r_q       <= n_q;
        r_neg     <= n_neg;
        r_cnt     <= n_cnt;
        r_o_value <= n_o_value;
        r_o_last  <= n_o_last;
        r_o_err   <= n_o_err;
    end

    assign o_stall       = (r_state != ST_IDLE);
    assign o_valid       = r_o_valid;
    assign o_value       = r_o_value;
    assign o_is_last     = r_o_last;
    assign o_range_error = r_o_err;

endmodule

// ----- hdl/mma_checker.sv -----
module mma_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic [1:0]         i_command,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [31:0] o_value,
    input logic               o_is_last,
    input logic               o_range_error
);
    import mma_pkg::*;

    // A held result keeps presenting.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_value) && $stable(o_is_last) &&
                               $stable(o_range_error))
        else $error("stalled result changed");

    // A real element keeps the block busy on the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (t_cmd'(i_command) != CMD_NOP) |=> o_stall)
        else $error("block took an element and did not go busy");

    // A new result only appears out of a busy period.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result appeared without work in progress");

endmodule

bind mma_approximation_evaluator_core mma_checker u_mma_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .i_command     (i_command),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_value       (o_value),
    .o_is_last     (o_is_last),
    .o_range_error (o_range_error)
);
